@@ rtl/core/phone_link_frame_parser_assert.svh @@
// Assertion macros for the phone link frame parser.
`ifndef PHONE_LINK_FRAME_PARSER_ASSERT_SVH
`define PHONE_LINK_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define PLFP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("plfp assertion failed");
`define PLFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plfp implication failed");
`else
`define PLFP_ASSERT(lbl, clk, rst_n, prop)
`define PLFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/plfp_pkg.sv @@
// Package for the phone link frame parser: parser state type and constants.
`timescale 1ns / 1ps
package plfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CFG_IDX_W = 8;

  typedef enum logic [2:0] {
    ST_SYNC  = 3'd0,
    ST_DEST  = 3'd1,
    ST_SRC   = 3'd2,
    ST_TYPE  = 3'd3,
    ST_LENHI = 3'd4,
    ST_LENLO = 3'd5,
    ST_DATA  = 3'd6
  } parse_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START = 8'd0,
    CFG_PC    = 8'd1,
    CFG_PHONE = 8'd2
  } cfg_reg_t;

  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_EMPTY   = 1'b1;

  localparam logic [BYTE_W-1:0] START_RST = 8'd28;
  localparam logic [BYTE_W-1:0] PC_RST    = 8'd12;
  localparam logic [BYTE_W-1:0] PHONE_RST = 8'd0;

endpackage

@@ rtl/core/phone_link_frame_parser.sv @@
// Phone link frame parser: header checks and payload byte streaming.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | rx_byte
//   out_    | output    | out_valid/out_stall| kind, byte, index, type, length, last
//   cfg_    | input     | cfg_valid/cfg_ready| index, data
//
// One byte per cycle while in_stall is low; each result is registered and appears in the cycle after its transfer.
// Rate is set by the single output register, which refills in the cycle it drains.
// in_stall rises only while a held result is stalled.
// Synchronous active-low reset clears the parser and loads register defaults.
`timescale 1ns / 1ps
`include "phone_link_frame_parser_assert.svh"
module phone_link_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_byte_index,
  output logic [7:0]  out_frame_type,
  output logic [15:0] out_frame_length,
  output logic        out_last_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] start_r, pc_r, phone_r;

  plfp_pkg::parse_state_t state_r, state_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [16:0] seen_inc;

  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_byte;
  logic [15:0] res_index;
  logic        res_last;

  logic        out_valid_r, out_valid_nxt;
  logic        kind_r;
  logic [7:0]  byte_r;
  logic [15:0] index_r;
  logic [7:0]  ftype_r;
  logic [15:0] flen_r;
  logic        last_r;

  logic in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= plfp_pkg::START_RST;
      pc_r    <= plfp_pkg::PC_RST;
      phone_r <= plfp_pkg::PHONE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        plfp_pkg::CFG_START: start_r <= cfg_data;
        plfp_pkg::CFG_PC:    pc_r    <= cfg_data;
        plfp_pkg::CFG_PHONE: phone_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign seen_inc = {1'b0, seen_r} + 17'd1;

  always_comb begin
    state_nxt = state_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    res_valid = 1'b0;
    res_kind  = plfp_pkg::RES_PAYLOAD;
    res_byte  = 8'd0;
    res_index = 16'd0;
    res_last  = 1'b0;
    case (state_r)
      plfp_pkg::ST_DEST: begin
        state_nxt = (in_rx_byte == pc_r) ? plfp_pkg::ST_SRC : plfp_pkg::ST_SYNC;
      end
      plfp_pkg::ST_SRC: begin
        state_nxt = (in_rx_byte == phone_r) ? plfp_pkg::ST_TYPE : plfp_pkg::ST_SYNC;
      end
      plfp_pkg::ST_TYPE: begin
        type_nxt  = in_rx_byte;
        state_nxt = plfp_pkg::ST_LENHI;
      end
      plfp_pkg::ST_LENHI: begin
        len_nxt   = {in_rx_byte, 8'd0};
        state_nxt = plfp_pkg::ST_LENLO;
      end
      plfp_pkg::ST_LENLO: begin
        len_nxt = {len_r[15:8], in_rx_byte};
        if (len_nxt == 16'd0) begin
          res_valid = 1'b1;
          res_kind  = plfp_pkg::RES_EMPTY;
          res_last  = 1'b1;
          state_nxt = plfp_pkg::ST_SYNC;
        end else begin
          state_nxt = plfp_pkg::ST_DATA;
        end
      end
      plfp_pkg::ST_DATA: begin
        res_valid = 1'b1;
        res_kind  = plfp_pkg::RES_PAYLOAD;
        res_byte  = in_rx_byte;
        res_index = seen_r;
        res_last  = (seen_inc == {1'b0, len_r});
        seen_nxt  = seen_inc[15:0];
        if (res_last) begin
          state_nxt = plfp_pkg::ST_SYNC;
        end
      end
      default: begin
        if (in_rx_byte == start_r) begin
          seen_nxt  = 16'd0;
          state_nxt = plfp_pkg::ST_DEST;
        end else begin
          state_nxt = plfp_pkg::ST_SYNC;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plfp_pkg::ST_SYNC;
      type_r  <= 8'd0;
      len_r   <= 16'd0;
      seen_r  <= 16'd0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = res_valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      kind_r  <= res_kind;
      byte_r  <= res_byte;
      index_r <= res_index;
      ftype_r <= type_nxt;
      flen_r  <= len_nxt;
      last_r  <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_payload_byte  = byte_r;
  assign out_byte_index    = index_r;
  assign out_frame_type    = ftype_r;
  assign out_frame_length  = flen_r;
  assign out_last_of_frame = last_r;

  `PLFP_ASSERT_IMPL(a_empty_fields, clk, rst_n,
    out_valid_r && (kind_r == plfp_pkg::RES_EMPTY),
    (byte_r == 8'd0) && (index_r == 16'd0) && last_r && (flen_r == 16'd0))
  `PLFP_ASSERT_IMPL(a_last_index, clk, rst_n,
    out_valid_r && (kind_r == plfp_pkg::RES_PAYLOAD) && last_r,
    ({1'b0, index_r} + 17'd1) == {1'b0, flen_r})
  `PLFP_ASSERT_IMPL(a_data_len, clk, rst_n,
    state_r == plfp_pkg::ST_DATA, (len_r != 16'd0) && (seen_r < len_r))
  `PLFP_ASSERT(a_no_result_in_header, clk, rst_n,
    (in_xfer && (state_r == plfp_pkg::ST_DEST || state_r == plfp_pkg::ST_SRC)) |=>
      !out_valid_r)

endmodule

@@ verif/tb.sv @@
// Testbench for phone_link_frame_parser: frame tracker, byte stimulus and result checks.
`timescale 1ns / 1ps

typedef struct packed {
  logic        kind;
  logic [7:0]  data;
  logic [15:0] idx;
  logic [7:0]  ftype;
  logic [15:0] flen;
  logic        last;
} frame_result_t;

class frame_parse_tracker;
  logic [7:0]             start_byte;
  logic [7:0]             pc_addr;
  logic [7:0]             phone_addr;
  plfp_pkg::parse_state_t phase;
  logic [7:0]             held_type;
  logic [15:0]            held_len;
  logic [15:0]            seen;
  frame_result_t          awaited[$];
  int unsigned            mismatches;

  function new();
    start_byte = plfp_pkg::START_RST;
    pc_addr    = plfp_pkg::PC_RST;
    phone_addr = plfp_pkg::PHONE_RST;
    phase      = plfp_pkg::ST_SYNC;
    held_type  = '0;
    held_len   = '0;
    seen       = '0;
    mismatches = 0;
  endfunction

  function void apply_reg(logic [7:0] idx, logic [7:0] val);
    case (idx)
      plfp_pkg::CFG_START: start_byte = val;
      plfp_pkg::CFG_PC:    pc_addr = val;
      plfp_pkg::CFG_PHONE: phone_addr = val;
      default: ;
    endcase
  endfunction

  function void note_rx_byte(logic [7:0] b);
    logic [16:0] nxt;
    logic        last;
    case (phase)
      plfp_pkg::ST_DEST: phase = (b == pc_addr) ? plfp_pkg::ST_SRC : plfp_pkg::ST_SYNC;
      plfp_pkg::ST_SRC:  phase = (b == phone_addr) ? plfp_pkg::ST_TYPE : plfp_pkg::ST_SYNC;
      plfp_pkg::ST_TYPE: begin
        held_type = b;
        phase = plfp_pkg::ST_LENHI;
      end
      plfp_pkg::ST_LENHI: begin
        held_len = {b, 8'h00};
        phase = plfp_pkg::ST_LENLO;
      end
      plfp_pkg::ST_LENLO: begin
        held_len = held_len | {8'h00, b};
        if (held_len == 16'h0000) begin
          awaited.push_back('{plfp_pkg::RES_EMPTY, 8'h00, 16'h0000, held_type, held_len,
                              1'b1});
          phase = plfp_pkg::ST_SYNC;
        end else begin
          phase = plfp_pkg::ST_DATA;
        end
      end
      plfp_pkg::ST_DATA: begin
        nxt = {1'b0, seen} + 17'd1;
        last = (nxt == {1'b0, held_len});
        awaited.push_back('{plfp_pkg::RES_PAYLOAD, b, seen, held_type, held_len, last});
        seen = nxt[15:0];
        if (last) phase = plfp_pkg::ST_SYNC;
      end
      default: begin
        if (b == start_byte) begin
          seen = '0;
          phase = plfp_pkg::ST_DEST;
        end else begin
          phase = plfp_pkg::ST_SYNC;
        end
      end
    endcase
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task cmp_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task check_delivery(frame_result_t got);
    frame_result_t want;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("unexpected result, byte %0h index %0d", got.data, got.idx));
    end else begin
      want = awaited.pop_front();
      cmp_field("result_kind", 16'(got.kind), 16'(want.kind));
      cmp_field("payload_byte", 16'(got.data), 16'(want.data));
      cmp_field("byte_index", got.idx, want.idx);
      cmp_field("frame_type", 16'(got.ftype), 16'(want.ftype));
      cmp_field("frame_length", got.flen, want.flen);
      cmp_field("last_of_frame", 16'(got.last), 16'(want.last));
    end
  endtask

  task flush_leftovers();
    if (awaited.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", awaited.size()));
  endtask
endclass

module tb;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_byte_index;
  logic [7:0]  out_frame_type;
  logic [15:0] out_frame_length;
  logic        out_last_of_frame;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;

  frame_parse_tracker tracker;
  frame_result_t      got_res;
  logic               quiet;
  int unsigned        gap_pct;
  int unsigned        idle_cycles;

  phone_link_frame_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_frame_type    (out_frame_type),
    .out_frame_length  (out_frame_length),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random stall bursts on the result side
  initial begin : out_backpressure
    int unsigned hold;
    out_stall <= 1'b0;
    forever begin
      hold = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
      repeat (hold) @(posedge clk);
      if (!quiet) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_res = '{out_result_kind, out_payload_byte, out_byte_index, out_frame_type,
                    out_frame_length, out_last_of_frame};
        tracker.check_delivery(got_res);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    tracker.note_rx_byte(b);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_header(input logic [7:0] typ, input logic [15:0] len);
    put_byte(tracker.start_byte);
    put_byte(tracker.pc_addr);
    put_byte(tracker.phone_addr);
    put_byte(typ);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
  endtask

  task automatic send_frame(input logic [7:0] typ, input logic [15:0] len);
    send_header(typ, len);
    for (int unsigned i = 0; i < len; i++) put_byte(8'($urandom));
  endtask

  // wait until every expected result is out, plus slack for header bytes in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.apply_reg(idx, val);
  endtask

  task automatic set_regs(input logic [7:0] sb, input logic [7:0] pc, input logic [7:0] ph);
    write_reg(plfp_pkg::CFG_START, sb);
    write_reg(8'($urandom_range(plfp_pkg::CFG_PHONE + 1, 255)), 8'($urandom));
    write_reg(plfp_pkg::CFG_PC, pc);
    write_reg(plfp_pkg::CFG_PHONE, ph);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned pick;
    int unsigned sel;
    int unsigned sent;
    int unsigned k;
    logic [15:0] len;
    tracker     = new();
    quiet      <= 1'b0;
    gap_pct     = 30;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    cfg_valid  <= 1'b0;
    cfg_index  <= plfp_pkg::CFG_START;
    cfg_data   <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: noise, empty frame, extremes, address mismatches
    put_byte(8'h00);
    put_byte(8'hFF);
    send_header(8'h00, 16'h0000);
    send_header(8'hFF, 16'h0001);
    put_byte(8'hFF);
    put_byte(tracker.start_byte);
    put_byte(tracker.start_byte);  // start byte as destination is not rescanned
    put_byte(tracker.start_byte);
    put_byte(tracker.pc_addr);
    put_byte(~tracker.phone_addr);
    send_header(8'h5A, 16'h0002);
    put_byte(8'h00);
    put_byte(8'h80);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: set_regs(8'h00, 8'h00, 8'h00);
        1: set_regs(8'hFF, 8'hFF, 8'hFF);
        2: set_regs(plfp_pkg::START_RST, plfp_pkg::PC_RST, plfp_pkg::PHONE_RST);
        default: set_regs(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      gap_pct = (ph == 3) ? 0 : $urandom_range(5, 40);
      sent = 0;
      while (sent < 100) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          sel = $urandom_range(0, 99);
          if (sel < 10) len = 16'd0;
          else if (sel < 80) len = 16'($urandom_range(1, 8));
          else if (sel < 97) len = 16'($urandom_range(9, 40));
          else len = 16'($urandom_range(256, 300));
          send_frame(8'($urandom), len);
          sent += 6 + len;
        end else if (pick < 80) begin
          put_byte(tracker.start_byte);
          put_byte(tracker.pc_addr ^ 8'($urandom_range(1, 255)));
          sent += 2;
        end else if (pick < 88) begin
          put_byte(tracker.start_byte);
          put_byte(tracker.pc_addr);
          put_byte(tracker.phone_addr ^ 8'($urandom_range(1, 255)));
          sent += 3;
        end else begin
          k = $urandom_range(1, 4);
          repeat (k) put_byte(8'($urandom));
          sent += k;
        end
      end
      // leave a header open so the next register change lands mid-frame
      if (ph % 2 == 1) begin
        put_byte(tracker.start_byte);
        put_byte(tracker.pc_addr);
      end
    end

    // last part: no idling, longest length field
    drain();
    quiet <= 1'b1;
    while (tracker.phase != plfp_pkg::ST_SYNC) put_byte(~tracker.start_byte);
    send_frame(8'($urandom), 16'h0003);
    send_header(8'($urandom), 16'h0000);
    // only the first payload bytes of the longest frame go out
    send_header(8'($urandom), 16'hFFFF);
    repeat (4) put_byte(8'($urandom));

    drain();
    repeat (12) @(posedge clk);
    tracker.flush_leftovers();
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
